// File: hdl/vn_pkg.sv
// constants and types for the vector normalizer
// no dependencies
package vn_pkg;

	localparam int COMP_W        = 32;
	localparam int LANES         = 4;
	localparam int OUT_FRAC_BITS = 30;
	localparam int N_ITER        = OUT_FRAC_BITS + 1;
	localparam int SQ_W          = 2 * COMP_W;
	localparam int SUM_W         = SQ_W + 1;
	localparam int REM_W         = SQ_W + 2 * OUT_FRAC_BITS;
	localparam int QACC_W        = SUM_W + OUT_FRAC_BITS + 1;
	localparam int ACC_W         = QACC_W + OUT_FRAC_BITS + 2;
	localparam int Q_W           = OUT_FRAC_BITS + 1;

	typedef logic [COMP_W-1:0] comp_t;
	typedef logic [REM_W-1:0]  rem_t;
	typedef logic [QACC_W-1:0] qacc_t;
	typedef logic [SUM_W-1:0]  sum_t;
	typedef logic [Q_W-1:0]    quo_t;

endpackage

// File: hdl/vector_normalize.sv
// vector_normalize: unit vector of a 3/4 component Q16.16 vector, Q2.30 result
// depends on vn_pkg
// throughput: one request per cycle; the output register, when stalled, holds
// the whole pipeline (in_stall follows out_stall while a result waits)
// reset: arst_n clears all valid bits at once; payload registers are not reset
module vector_normalize import vn_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_stall,
	input  logic [31:0]  comp_x,
	input  logic [31:0]  comp_y,
	input  logic [31:0]  comp_z,
	input  logic [31:0]  comp_w,
	input  logic         four_wide,
	output logic         out_valid,
	input  logic         out_stall,
	output logic [31:0]  unit_x,
	output logic [31:0]  unit_y,
	output logic [31:0]  unit_z,
	output logic [31:0]  unit_w,
	output logic         was_zero
);

	// whole pipeline moves together; it only halts on a waiting, stalled result
	logic adv;
	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;

	comp_t comp_in [LANES];
	assign comp_in[0] = comp_x;
	assign comp_in[1] = comp_y;
	assign comp_in[2] = comp_z;
	assign comp_in[3] = comp_w;

	// stage 1: magnitudes and signs; the fourth lane is zeroed when three wide
	logic  v_s1;
	comp_t mag_s1 [LANES];
	logic  neg_s1 [LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	for (genvar l = 0; l < LANES; l++) begin : g_mag
		logic on;
		assign on = (l < LANES - 1) || four_wide;
		always_ff @(posedge clk) begin
			if (adv) begin
				mag_s1[l] <= on ? (comp_in[l][COMP_W-1] ? (~comp_in[l] + 1'b1) : comp_in[l])
					: '0;
				neg_s1[l] <= on && comp_in[l][COMP_W-1];
			end
		end
	end

	// stage 2: squares, one 32x32 multiplier per lane
	logic            v_s2;
	logic [SQ_W-1:0] sq_s2 [LANES];
	logic            neg_s2 [LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	for (genvar l = 0; l < LANES; l++) begin : g_sq
		always_ff @(posedge clk) begin
			if (adv) begin
				sq_s2[l]  <= SQ_W'(mag_s1[l]) * SQ_W'(mag_s1[l]);
				neg_s2[l] <= neg_s1[l];
			end
		end
	end

	// stage 3 and the bit stages: index 0 is loaded from the squares,
	// index k+1 holds the quotient after bit OUT_FRAC_BITS-k is settled
	// per lane: rem = a^2*2^60 - q^2*S, qacc = q*S
	logic  vld_sn  [N_ITER+1];
	sum_t  sum_sn  [N_ITER+1];
	logic  zero_sn [N_ITER+1];
	rem_t  rem_sn  [N_ITER+1][LANES];
	qacc_t qacc_sn [N_ITER+1][LANES];
	quo_t  quo_sn  [N_ITER+1][LANES];
	logic  neg_sn  [N_ITER+1][LANES];

	sum_t sum_c;
	assign sum_c = SUM_W'(sq_s2[0]) + SUM_W'(sq_s2[1]) + SUM_W'(sq_s2[2]) + SUM_W'(sq_s2[3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sn[0] <= 1'b0;
		end else if (adv) begin
			vld_sn[0] <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_sn[0]  <= sum_c;
			zero_sn[0] <= (sum_c == '0);
		end
	end

	for (genvar l = 0; l < LANES; l++) begin : g_init
		always_ff @(posedge clk) begin
			if (adv) begin
				rem_sn[0][l]  <= {sq_s2[l], {(2 * OUT_FRAC_BITS){1'b0}}};
				qacc_sn[0][l] <= '0;
				quo_sn[0][l]  <= '0;
				neg_sn[0][l]  <= neg_s2[l];
			end
		end
	end

	// one quotient bit per stage, restoring style with shifts and adds only:
	// (q + 2^b)^2 * S = q^2*S + (q*S)<<(b+1) + S<<2b
	for (genvar k = 0; k < N_ITER; k++) begin : g_bit
		localparam int B = OUT_FRAC_BITS - k;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sn[k+1] <= 1'b0;
			end else if (adv) begin
				vld_sn[k+1] <= vld_sn[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sum_sn[k+1]  <= sum_sn[k];
				zero_sn[k+1] <= zero_sn[k];
			end
		end

		for (genvar l = 0; l < LANES; l++) begin : g_lane
			logic [ACC_W-1:0] dlt;
			logic             take;

			assign dlt  = (ACC_W'(qacc_sn[k][l]) << (B + 1)) + (ACC_W'(sum_sn[k]) << (2 * B));
			assign take = dlt <= ACC_W'(rem_sn[k][l]);

			always_ff @(posedge clk) begin
				if (adv) begin
					rem_sn[k+1][l]  <= take ? REM_W'(ACC_W'(rem_sn[k][l]) - dlt) : rem_sn[k][l];
					qacc_sn[k+1][l] <= take ? qacc_sn[k][l] + (QACC_W'(sum_sn[k]) << B)
						: qacc_sn[k][l];
					quo_sn[k+1][l]  <= quo_sn[k][l] | (Q_W'(take) << B);
					neg_sn[k+1][l]  <= neg_sn[k][l];
				end
			end
		end
	end

	// output register: sign restore, zero length forces all zeros
	comp_t unit_q [LANES];
	logic  zero_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= vld_sn[N_ITER];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			zero_q <= zero_sn[N_ITER];
		end
	end

	for (genvar l = 0; l < LANES; l++) begin : g_out
		comp_t mag;
		assign mag = COMP_W'(quo_sn[N_ITER][l]);
		always_ff @(posedge clk) begin
			if (adv) begin
				unit_q[l] <= zero_sn[N_ITER] ? '0 : (neg_sn[N_ITER][l] ? (~mag + 1'b1) : mag);
			end
		end
	end

	assign unit_x   = unit_q[0];
	assign unit_y   = unit_q[1];
	assign unit_z   = unit_q[2];
	assign unit_w   = unit_q[3];
	assign was_zero = zero_q;

endmodule

// File: hdl/vn_check.sv
// port-level checks for vector_normalize, bound to the top level
// depends on vn_pkg
module vn_check import vn_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] unit_x,
	input logic [31:0] unit_y,
	input logic [31:0] unit_z,
	input logic [31:0] unit_w,
	input logic        was_zero
);

	localparam logic signed [31:0] ONE  = 32'sd1 <<< OUT_FRAC_BITS;
	localparam logic signed [31:0] MONE = -ONE;

	// a stalled result stays
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// input only pushes back while a result waits
	a_back: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("request stalled without a waiting result");

	// zero length gives an all-zero vector
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && was_zero |-> unit_x == '0 && unit_y == '0 && unit_z == '0 && unit_w == '0)
		else $error("zero-length result not cleared");

	// components stay within plus or minus one
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $signed(unit_x) <= ONE && $signed(unit_x) >= MONE
			&& $signed(unit_y) <= ONE && $signed(unit_y) >= MONE
			&& $signed(unit_z) <= ONE && $signed(unit_z) >= MONE
			&& $signed(unit_w) <= ONE && $signed(unit_w) >= MONE)
		else $error("component out of range");

endmodule

bind vector_normalize vn_check u_vn_check (.*);

// File: dv/vector_normalize_tb.sv
// testbench for vector_normalize: random and directed vectors, scoreboard on a local model
// depends on the vector_normalize rtl
module vector_normalize_tb;

	typedef struct packed {
		logic [31:0] x, y, z, w;
		logic        four;
	} vec_req_t;

	typedef struct packed {
		logic [31:0] x, y, z, w;
		logic        zero;
	} unit_res_t;

	localparam int LIMIT_CYCLES = 400000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] comp_x = '0, comp_y = '0, comp_z = '0, comp_w = '0;
	logic        four_wide = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] unit_x, unit_y, unit_z, unit_w;
	logic        was_zero;

	vec_req_t  pending_reqs[$];
	unit_res_t expected_units[$];
	int        n_errors = 0;
	int        cycle_count = 0;
	int        send_idle_pct = 0;
	int        stall_pct = 0;
	int        hold_off = 0;
	bit        hold_go = 1'b0;
	bit        hold_done = 1'b0;

	vector_normalize u_top (.*);

	always #2 clk = ~clk;

	// magnitude of a two's complement component, -2^31 kept exact
	function automatic logic [32:0] comp_mag(logic [31:0] v);
		return v[31] ? 33'(-$signed({1'b1, v})) : {1'b0, v};
	endfunction

	// largest q with q^2 * s <= a^2 * 2^60, bit by bit from the top
	function automatic logic [30:0] unit_quot(logic [32:0] a, logic [65:0] s);
		logic [127:0] goal;
		logic [127:0] lhs;
		logic [30:0]  q;
		logic [30:0]  cand;
		goal = ({95'd0, a} * {95'd0, a}) << 60;
		q = '0;
		for (int b = 30; b >= 0; b--) begin
			cand = q | (31'd1 << b);
			lhs = {97'd0, cand} * {97'd0, cand} * {62'd0, s};
			if (lhs <= goal)
				q = cand;
		end
		return q;
	endfunction

	function automatic unit_res_t normalize_vec(vec_req_t r);
		unit_res_t   u;
		logic [32:0] m[4];
		logic [31:0] c[4];
		logic [31:0] o[4];
		logic [65:0] s;
		logic [30:0] q;
		int          n;
		c = '{r.x, r.y, r.z, r.w};
		n = r.four ? 4 : 3;
		s = '0;
		for (int i = 0; i < 4; i++) begin
			m[i] = comp_mag(c[i]);
			o[i] = '0;
		end
		for (int i = 0; i < n; i++)
			s += {33'd0, m[i]} * {33'd0, m[i]};
		u.zero = (s == 0);
		if (!u.zero) begin
			for (int i = 0; i < n; i++) begin
				q = unit_quot(m[i], s);
				o[i] = c[i][31] ? -{1'b0, q} : {1'b0, q};
			end
		end
		u.x = o[0]; u.y = o[1]; u.z = o[2]; u.w = o[3];
		return u;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h expected %h", what, got, want);
		n_errors++;
	endtask

	// random component: often full-range, some small, some extremes
	function automatic logic [31:0] rand_comp();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return '0;
			3, 4: return 32'($signed($urandom_range(0, 64)) - 32);
			5: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
			default: return $urandom;
		endcase
	endfunction

	task automatic add_req(logic [31:0] x, y, z, w, logic f);
		vec_req_t r;
		r = '{x: x, y: y, z: z, w: w, four: f};
		pending_reqs.push_back(r);
	endtask

	// driver: one request offered per cycle unless idling; payload held while stalled
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expected_units.push_back(normalize_vec({comp_x, comp_y, comp_z, comp_w,
					four_wide}));
			end
			if (!in_valid || !in_stall) begin
				if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					vec_req_t r;
					r = pending_reqs.pop_front();
					in_valid <= 1'b1;
					{comp_x, comp_y, comp_z, comp_w, four_wide} <= r;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver stall: random, or a long hold-off counted down here
	always @(posedge clk) begin
		if (hold_go && !hold_done) begin
			hold_done <= 1'b1;
			hold_off <= 120;
			out_stall <= 1'b1;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	// monitor: compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		unit_res_t e;
		cycle_count <= cycle_count + 1;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_units.size() == 0) begin
				report_mismatch("unexpected result", unit_x, '0);
			end else begin
				e = expected_units.pop_front();
				if (unit_x !== e.x) report_mismatch("unit_x", unit_x, e.x);
				if (unit_y !== e.y) report_mismatch("unit_y", unit_y, e.y);
				if (unit_z !== e.z) report_mismatch("unit_z", unit_z, e.z);
				if (unit_w !== e.w) report_mismatch("unit_w", unit_w, e.w);
				if (was_zero !== e.zero) report_mismatch("was_zero", 32'(was_zero), 32'(e.zero));
			end
		end
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("timeout");
			$display("Regression FAIL");
			$finish;
		end
	end

	// wait until the driver has handed over every queued request
	task automatic drain_reqs();
		while (pending_reqs.size() > 0 || (in_valid && in_stall))
			@(posedge clk);
		@(posedge clk);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero length, extremes, axis vectors, three vs four wide
		add_req(0, 0, 0, 0, 1'b0);
		add_req(0, 0, 0, 0, 1'b1);
		add_req(0, 0, 0, 32'h1234_5678, 1'b0);
		add_req(0, 0, 0, 32'h8000_0000, 1'b1);
		add_req(32'h8000_0000, 0, 0, 0, 1'b0);
		add_req(32'h7fff_ffff, 0, 0, 0, 1'b0);
		add_req(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
		add_req(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1);
		add_req(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1'b0);
		add_req(1, 0, 0, 0, 1'b0);
		add_req(0, 32'hffff_ffff, 0, 0, 1'b0);
		add_req(0, 0, 1, 0, 1'b0);
		add_req(0, 0, 0, 32'hffff_ffff, 1'b1);
		add_req(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b1);
		add_req(3, 4, 0, 99, 1'b0);
		add_req(32'hffff_fffd, 32'hffff_fffc, 12, 0, 1'b1);
		add_req(1, 1, 1, 32'h7fff_ffff, 1'b1);
		add_req(32'haaaa_aaaa, 32'h5555_5555, 32'hffff_0000, 32'h0000_ffff, 1'b1);
		drain_reqs();

		// random phases: none, sender idle, receiver stall, both
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 68 : 23) : 0;
			stall_pct     = (ph == 2 || ph == 3) ? ((ph == 2) ? 68 : 23) : 0;
			for (int i = 0; i < 270; i++)
				add_req(rand_comp(), rand_comp(), rand_comp(), rand_comp(),
					1'($urandom_range(0, 1)));
			// long hold-off while the sender keeps offering, so the pipeline fills
			if (ph == 0) begin
				repeat (20) @(posedge clk);
				hold_go = 1'b1;
			end
			drain_reqs();
		end
		stall_pct = 0;
		send_idle_pct = 0;

		while (expected_units.size() > 0 || in_valid)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (n_errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
